// ===== hdl/ckmbf_pkg.sv =====
package ckmbf_pkg;

  localparam int MaxLevelsLog = 10;
  localparam int EdgeW        = MaxLevelsLog + 1;
  localparam int CntW         = MaxLevelsLog;
  localparam int StoreDepth   = 2 << MaxLevelsLog;
  localparam int StoreAw      = $clog2(StoreDepth);
  localparam int HoldDepth    = MaxLevelsLog + 1;
  localparam int HoldAw       = $clog2(HoldDepth);

  localparam int LevelW = 4;
  localparam int PosW   = 10;
  localparam int PixW   = 32;
  localparam int ChanW  = 8;
  localparam int KeyW   = 24;
  localparam int SizeW  = 4;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 24;

  localparam logic [ChanW-1:0] OpaqueAlpha = 8'hff;
  localparam logic [ChanW-1:0] ClearAlpha  = 8'h00;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SIZE_LOG2   = 2'd0,
    CFG_LEVEL_COUNT = 2'd1,
    CFG_KEY_COLOR   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_RD0,
    ST_RD1,
    ST_RD2
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic load_out;
    logic out_last;
    logic store_we;
    logic hold_we;
    logic rd_first;
    logic capture_a;
    logic advance;
  } ctrl_t;

endpackage

// ===== hdl/ckmbf_if.sv =====
interface ckmbf_pix_if;
  logic                       valid;
  logic                       ready;
  logic [ckmbf_pkg::PixW-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface ckmbf_mip_if;
  logic                         valid;
  logic                         ready;
  logic [ckmbf_pkg::LevelW-1:0] mip_level;
  logic [ckmbf_pkg::PosW-1:0]   pos_x;
  logic [ckmbf_pkg::PosW-1:0]   pos_y;
  logic [ckmbf_pkg::PixW-1:0]   pixel_out;
  logic                         last_of_run;

  modport source (output valid, output mip_level, output pos_x, output pos_y,
                  output pixel_out, output last_of_run, input ready);
  modport sink   (input valid, input mip_level, input pos_x, input pos_y,
                  input pixel_out, input last_of_run, output ready);
endinterface

interface ckmbf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ckmbf_pkg::CfgIdxW-1:0]  reg_index;
  logic [ckmbf_pkg::CfgDataW-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== hdl/ckmbf_avg.sv =====
module ckmbf_avg (
  input  logic [ckmbf_pkg::PixW-1:0] pix_a,
  input  logic [ckmbf_pkg::PixW-1:0] pix_b,
  input  logic [ckmbf_pkg::PixW-1:0] pix_c,
  input  logic [ckmbf_pkg::PixW-1:0] pix_d,
  output logic [ckmbf_pkg::PixW-1:0] pix_avg
);

  localparam int NumChan = ckmbf_pkg::PixW / ckmbf_pkg::ChanW;
  localparam int SumW    = ckmbf_pkg::ChanW + 2;

  always_comb begin
    logic [SumW-1:0] sum;
    pix_avg = '0;
    for (int c = 0; c < NumChan; c++) begin
      sum = SumW'(pix_a[c*ckmbf_pkg::ChanW +: ckmbf_pkg::ChanW])
          + SumW'(pix_b[c*ckmbf_pkg::ChanW +: ckmbf_pkg::ChanW])
          + SumW'(pix_c[c*ckmbf_pkg::ChanW +: ckmbf_pkg::ChanW])
          + SumW'(pix_d[c*ckmbf_pkg::ChanW +: ckmbf_pkg::ChanW]);
      pix_avg[c*ckmbf_pkg::ChanW +: ckmbf_pkg::ChanW] = sum[SumW-1:2];
    end
  end

endmodule

// ===== hdl/color_keyed_mipmap_box_filter_core.sv =====
// Streaming mipmap builder: base ARGB pixels enter in raster order, each is
// color keyed (an opaque pixel whose RGB equals key_color gets alpha 0) and
// returned as level 0, and every finished 2x2 block of a level is averaged
// per channel (sum / 4, truncated) into the next level, up to level_count
// levels. Results of one pixel come in ascending level order with
// last_of_run on the final one. For each reduced level a pixel produces,
// the single read port of the row store is visited twice and the shared
// averaging unit once; an output stall holds the run until it clears.
// The input is not ready while a pixel is in work. Writing size_log2 or
// level_count restarts the frame at position 0,0; configure only while
// idle. No clearing pass is needed after reset.
module color_keyed_mipmap_box_filter_core (
  input  logic             clk,
  input  logic             rst_n,
  ckmbf_pix_if.sink        in_ch,
  ckmbf_mip_if.source      out_ch,
  ckmbf_cfg_if.sink        cfg_ch
);

  ckmbf_pkg::state_t state_r, state_nxt;
  ckmbf_pkg::ctrl_t  ctrl;

  logic [ckmbf_pkg::SizeW-1:0] size_log2_r;
  logic [ckmbf_pkg::SizeW-1:0] level_count_r;
  logic [ckmbf_pkg::KeyW-1:0]  key_color_r;
  logic [ckmbf_pkg::CntW-1:0]  col_count_r, col_count_nxt;
  logic [ckmbf_pkg::CntW-1:0]  row_count_r, row_count_nxt;

  logic [ckmbf_pkg::PixW-1:0]    pix_r;
  logic [ckmbf_pkg::CntW-1:0]    x_r;
  logic [ckmbf_pkg::CntW-1:0]    y_r;
  logic [ckmbf_pkg::HoldAw-1:0]  k_r;
  logic [ckmbf_pkg::StoreAw-1:0] off_r;
  logic [ckmbf_pkg::PixW-1:0]    a_r;

  logic [ckmbf_pkg::PixW-1:0] row_store [ckmbf_pkg::StoreDepth];
  logic [ckmbf_pkg::PixW-1:0] left_hold [ckmbf_pkg::HoldDepth];
  logic [ckmbf_pkg::PixW-1:0] rd_data_r;
  logic [ckmbf_pkg::PixW-1:0] hold_data_r;

  logic                         out_valid_r;
  logic [ckmbf_pkg::LevelW-1:0] out_level_r;
  logic [ckmbf_pkg::PosW-1:0]   out_x_r;
  logic [ckmbf_pkg::PosW-1:0]   out_y_r;
  logic [ckmbf_pkg::PixW-1:0]   out_pix_r;
  logic                         out_last_r;

  logic [ckmbf_pkg::SizeW-1:0]   s_eff;
  logic [ckmbf_pkg::SizeW-1:0]   l_eff;
  logic [ckmbf_pkg::EdgeW-1:0]   edge_len;
  logic                          in_acc;
  logic                          cfg_acc;
  logic                          slot_free;
  logic                          stop_here;
  logic [ckmbf_pkg::StoreAw-1:0] wr_addr;
  logic [ckmbf_pkg::StoreAw-1:0] rd_addr;
  logic [ckmbf_pkg::PixW-1:0]    keyed_pix;
  logic [ckmbf_pkg::PixW-1:0]    avg_pix;
  logic [ckmbf_pkg::EdgeW-1:0]   col_inc;
  logic [ckmbf_pkg::EdgeW-1:0]   row_inc;

  assign s_eff = (size_log2_r > ckmbf_pkg::SizeW'(ckmbf_pkg::MaxLevelsLog))
               ? ckmbf_pkg::SizeW'(ckmbf_pkg::MaxLevelsLog) : size_log2_r;
  assign l_eff    = (level_count_r > s_eff) ? s_eff : level_count_r;
  assign edge_len = ckmbf_pkg::EdgeW'(1) << s_eff;

  assign in_ch.ready  = ctrl.in_ready;
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid & ctrl.in_ready;
  assign cfg_acc      = cfg_ch.valid;

  assign keyed_pix = (in_ch.pixel_in == {ckmbf_pkg::OpaqueAlpha, key_color_r})
                   ? {ckmbf_pkg::ClearAlpha, in_ch.pixel_in[ckmbf_pkg::KeyW-1:0]}
                   : in_ch.pixel_in;

  assign slot_free = ~out_valid_r | out_ch.ready;
  assign stop_here = (ckmbf_pkg::SizeW'(k_r) >= l_eff) | ~y_r[0] | ~x_r[0];
  assign wr_addr   = off_r + ckmbf_pkg::StoreAw'(x_r);
  assign rd_addr   = ctrl.rd_first ? wr_addr - ckmbf_pkg::StoreAw'(1) : wr_addr;

  ckmbf_avg u_avg (
    .pix_a   (a_r),
    .pix_b   (rd_data_r),
    .pix_c   (hold_data_r),
    .pix_d   (pix_r),
    .pix_avg (avg_pix)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ckmbf_pkg::ST_IDLE: if (in_acc) state_nxt = ckmbf_pkg::ST_EMIT;
      ckmbf_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_nxt = stop_here ? ckmbf_pkg::ST_IDLE : ckmbf_pkg::ST_RD0;
        end
      end
      ckmbf_pkg::ST_RD0:  state_nxt = ckmbf_pkg::ST_RD1;
      ckmbf_pkg::ST_RD1:  state_nxt = ckmbf_pkg::ST_RD2;
      ckmbf_pkg::ST_RD2:  state_nxt = ckmbf_pkg::ST_EMIT;
      default:            state_nxt = ckmbf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      ckmbf_pkg::ST_IDLE: ctrl.in_ready = 1'b1;
      ckmbf_pkg::ST_EMIT: begin
        ctrl.load_out = slot_free;
        ctrl.out_last = stop_here;
        if (slot_free && stop_here && (ckmbf_pkg::SizeW'(k_r) < l_eff)) begin
          ctrl.store_we = ~y_r[0];
          ctrl.hold_we  = y_r[0];
        end
      end
      ckmbf_pkg::ST_RD0:  ctrl.rd_first  = 1'b1;
      ckmbf_pkg::ST_RD1:  ctrl.capture_a = 1'b1;
      ckmbf_pkg::ST_RD2:  ctrl.advance   = 1'b1;
      default:            ctrl = '0;
    endcase
  end

  assign col_inc = ckmbf_pkg::EdgeW'(col_count_r) + ckmbf_pkg::EdgeW'(1);
  assign row_inc = ckmbf_pkg::EdgeW'(row_count_r) + ckmbf_pkg::EdgeW'(1);

  always_comb begin
    col_count_nxt = col_count_r;
    row_count_nxt = row_count_r;
    if (in_acc) begin
      if (col_inc >= edge_len) begin
        col_count_nxt = '0;
        row_count_nxt = (row_inc >= edge_len) ? '0 : row_inc[ckmbf_pkg::CntW-1:0];
      end else begin
        col_count_nxt = col_inc[ckmbf_pkg::CntW-1:0];
      end
    end
    if (cfg_acc && ((cfg_ch.reg_index == ckmbf_pkg::CFG_SIZE_LOG2) ||
                    (cfg_ch.reg_index == ckmbf_pkg::CFG_LEVEL_COUNT))) begin
      col_count_nxt = '0;
      row_count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ckmbf_pkg::ST_IDLE;
      size_log2_r   <= '0;
      level_count_r <= '0;
      key_color_r   <= '0;
      col_count_r   <= '0;
      row_count_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
      if (cfg_acc) begin
        case (cfg_ch.reg_index)
          ckmbf_pkg::CFG_SIZE_LOG2:   size_log2_r   <= cfg_ch.wdata[ckmbf_pkg::SizeW-1:0];
          ckmbf_pkg::CFG_LEVEL_COUNT: level_count_r <= cfg_ch.wdata[ckmbf_pkg::SizeW-1:0];
          ckmbf_pkg::CFG_KEY_COLOR:   key_color_r   <= cfg_ch.wdata[ckmbf_pkg::KeyW-1:0];
          default: ;
        endcase
      end
      if (ctrl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_r <= keyed_pix;
      x_r   <= col_count_r;
      y_r   <= row_count_r;
      k_r   <= '0;
      off_r <= '0;
    end else if (ctrl.advance) begin
      pix_r <= avg_pix;
      x_r   <= x_r >> 1;
      y_r   <= y_r >> 1;
      k_r   <= k_r + ckmbf_pkg::HoldAw'(1);
      off_r <= off_r + ckmbf_pkg::StoreAw'(edge_len >> k_r);
    end
    if (ctrl.capture_a) begin
      a_r <= rd_data_r;
    end
    if (ctrl.load_out) begin
      out_level_r <= ckmbf_pkg::LevelW'(k_r);
      out_x_r     <= ckmbf_pkg::PosW'(x_r);
      out_y_r     <= ckmbf_pkg::PosW'(y_r);
      out_pix_r   <= pix_r;
      out_last_r  <= ctrl.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.store_we) begin
      row_store[wr_addr] <= pix_r;
    end
    rd_data_r <= row_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.hold_we) begin
      left_hold[k_r] <= pix_r;
    end
    hold_data_r <= left_hold[k_r];
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.mip_level   = out_level_r;
  assign out_ch.pos_x       = out_x_r;
  assign out_ch.pos_y       = out_y_r;
  assign out_ch.pixel_out   = out_pix_r;
  assign out_ch.last_of_run = out_last_r;

endmodule

// ===== hdl/ckmbf_checker.sv =====
module ckmbf_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ckmbf_pkg::LevelW-1:0] out_mip_level,
  input logic [ckmbf_pkg::PosW-1:0]   out_pos_x,
  input logic [ckmbf_pkg::PosW-1:0]   out_pos_y,
  input logic [ckmbf_pkg::PixW-1:0]   out_pixel_out,
  input logic                         out_last_of_run,
  input logic                         cfg_valid,
  input logic                         cfg_ready
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a transaction");

  a_pending_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && out_valid) |-> out_last_of_run)
    else $error("new input taken while a run is unfinished");

  a_cfg_always_taken: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_mip_level) &&
      $stable(out_pos_x) && $stable(out_pos_y) && $stable(out_pixel_out) &&
      $stable(out_last_of_run)))
    else $error("stalled result changed");

endmodule

bind color_keyed_mipmap_box_filter_core ckmbf_checker u_ckmbf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_mip_level   (out_ch.mip_level),
  .out_pos_x       (out_ch.pos_x),
  .out_pos_y       (out_ch.pos_y),
  .out_pixel_out   (out_ch.pixel_out),
  .out_last_of_run (out_ch.last_of_run),
  .cfg_valid       (cfg_ch.valid),
  .cfg_ready       (cfg_ch.ready)
);
